@@ src/swcfd_pkg.sv @@
// Shared types, constants and the CRC-8 step function of the sensor word frame decoder.
package swcfd_pkg;

  localparam int unsigned BYTE_POS_W = 4;

  localparam logic [BYTE_POS_W-1:0] POS_IDLE     = 4'd0;
  localparam logic [BYTE_POS_W-1:0] POS_CO2_HI   = 4'd0;
  localparam logic [BYTE_POS_W-1:0] POS_CO2_LO   = 4'd1;
  localparam logic [BYTE_POS_W-1:0] POS_CO2_CRC  = 4'd2;
  localparam logic [BYTE_POS_W-1:0] POS_TEMP_HI  = 4'd3;
  localparam logic [BYTE_POS_W-1:0] POS_TEMP_LO  = 4'd4;
  localparam logic [BYTE_POS_W-1:0] POS_TEMP_CRC = 4'd5;
  localparam logic [BYTE_POS_W-1:0] POS_HUM_HI   = 4'd6;
  localparam logic [BYTE_POS_W-1:0] POS_HUM_LO   = 4'd7;
  localparam logic [BYTE_POS_W-1:0] POS_HUM_CRC  = 4'd8;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [14:0]        TEMP_SCALE  = 15'd17500;
  localparam logic [13:0]        HUM_SCALE   = 14'd10000;
  localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;
  localparam logic [16:0]        FULL_SCALE  = 17'd65535;
  localparam logic [13:0]        HUM_MAX     = 14'd10000;

  typedef struct packed {
    logic [15:0] co2;
    logic [15:0] thermal;
    logic [15:0] humid;
    logic        crc_ok;
  } swcfd_frame_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ src/swcfd_front.sv @@
// Front end: takes response bytes, checks word CRCs and assembles the three raw words.
module swcfd_front
  import swcfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,  // data_byte
  input  logic         in_tuser,  // frame_start
  input  logic         q_full,
  output logic         push,
  output swcfd_frame_t frame
);

  logic [BYTE_POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic [7:0]            crc_r, crc_nxt;
  logic [7:0]            high_r, high_nxt;
  logic                  err_r, err_nxt, err_eff;
  logic [15:0]           co2_r, co2_nxt;
  logic [15:0]           thermal_r, thermal_nxt;
  logic [15:0]           humid_r, humid_nxt;
  logic                  fire;

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  always_comb begin
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    high_nxt    = high_r;
    err_nxt     = err_r;
    co2_nxt     = co2_r;
    thermal_nxt = thermal_r;
    humid_nxt   = humid_r;
    pos_eff     = in_tuser ? POS_IDLE : pos_r;
    err_eff     = in_tuser ? 1'b0 : err_r;
    push        = 1'b0;
    if (fire && (in_tuser || pos_r != POS_IDLE)) begin
      unique case (pos_eff) inside
        POS_CO2_HI, POS_TEMP_HI, POS_HUM_HI: begin
          high_nxt = in_tdata;
          crc_nxt  = crc8_update(CRC_INIT, in_tdata);
        end
        POS_CO2_LO, POS_TEMP_LO, POS_HUM_LO: begin
          crc_nxt = crc8_update(crc_r, in_tdata);
          unique case (pos_eff)
            POS_CO2_LO:  co2_nxt     = {high_r, in_tdata};
            POS_TEMP_LO: thermal_nxt = {high_r, in_tdata};
            default:     humid_nxt   = {high_r, in_tdata};
          endcase
        end
        default: begin
          if (crc_r != in_tdata) begin
            err_eff = 1'b1;
          end
          crc_nxt = CRC_INIT;
        end
      endcase
      if (pos_eff == POS_HUM_CRC) begin
        pos_nxt = POS_IDLE;
        err_nxt = 1'b0;
        push    = 1'b1;
      end else begin
        pos_nxt = pos_eff + 1'b1;
        err_nxt = err_eff;
      end
    end
  end

  always_comb begin
    frame.co2     = co2_r;
    frame.thermal = thermal_r;
    frame.humid   = humid_r;
    frame.crc_ok  = !err_eff;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_IDLE;
      crc_r <= CRC_INIT;
      err_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    high_r    <= high_nxt;
    co2_r     <= co2_nxt;
    thermal_r <= thermal_nxt;
    humid_r   <= humid_nxt;
  end

endmodule

@@ src/swcfd_queue.sv @@
// Small first-in first-out queue of assembled frames between front and back end.
module swcfd_queue
  import swcfd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  swcfd_frame_t push_data,
  input  logic         pop,
  output logic         head_valid,
  output swcfd_frame_t head,
  output logic         full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  swcfd_frame_t     mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ src/swcfd_back.sv @@
// Back end: scales the raw words to centi-units in three pipeline stages and holds the result.
module swcfd_back
  import swcfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         head_valid,
  input  swcfd_frame_t head,
  output logic         pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [47:0]  out_tdata,
  output logic         out_tuser
);

  logic        adv;
  logic        v_a_r, v_b_r, out_valid_r;

  logic [30:0] tmul_a_r;
  logic [29:0] hmul_a_r;
  logic [15:0] co2_a_r;
  logic        ok_a_r;

  logic [31:0] tsum;
  logic [30:0] hsum;
  logic [30:0] tx_b_r;
  logic [29:0] hx_b_r;
  logic [14:0] tq1_b_r;
  logic [13:0] hq1_b_r;
  logic [15:0] co2_b_r;
  logic        ok_b_r;

  logic [31:0]        trem;
  logic [30:0]        hrem;
  logic [14:0]        tq;
  logic [13:0]        hq;
  logic signed [15:0] temp_wide;
  logic [47:0]        out_data_nxt;
  logic [47:0]        out_data_r;
  logic               out_user_r;

  assign adv        = !out_valid_r || out_tready;
  assign pop        = adv && head_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign tsum = 32'(tmul_a_r) + 32'(tmul_a_r[30:16]);
  assign hsum = 31'(hmul_a_r) + 31'(hmul_a_r[29:16]);

  always_comb begin
    trem      = 32'(tx_b_r) - (32'(tq1_b_r) << 16) + 32'(tq1_b_r);
    hrem      = 31'(hx_b_r) - (31'(hq1_b_r) << 16) + 31'(hq1_b_r);
    tq        = tq1_b_r + 15'(trem[16:0] >= FULL_SCALE);
    hq        = hq1_b_r + 14'(hrem[16:0] >= FULL_SCALE);
    temp_wide = $signed({1'b0, tq}) - TEMP_OFFSET;
    if (ok_b_r) begin
      out_data_nxt = {3'b000, hq, temp_wide[14:0], co2_b_r};
    end else begin
      out_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r       <= 1'b0;
      v_b_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_a_r       <= head_valid;
      v_b_r       <= v_a_r;
      out_valid_r <= v_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tmul_a_r   <= 31'(head.thermal) * 31'(TEMP_SCALE);
      hmul_a_r   <= 30'(head.humid) * 30'(HUM_SCALE);
      co2_a_r    <= head.co2;
      ok_a_r     <= head.crc_ok;
      tx_b_r     <= tmul_a_r;
      hx_b_r     <= hmul_a_r;
      tq1_b_r    <= tsum[30:16];
      hq1_b_r    <= hsum[29:16];
      co2_b_r    <= co2_a_r;
      ok_b_r     <= ok_a_r;
      out_data_r <= out_data_nxt;
      out_user_r <= ok_b_r;
    end
  end

endmodule

@@ src/sensor_word_crc_frame_decoder.sv @@
// Top level of the sensor word frame decoder with CRC-8 word checking.
// The block takes one response byte per transfer and accepts a byte in every cycle while its
// frame queue has room. A byte with in_tuser high starts a nine-byte response, and bytes
// outside a response are dropped. Once a response's ninth byte is accepted, the frame passes
// through the frame queue and the back end's stage a, stage b and output registers before
// out_tvalid rises. The result carries the CO2 word, the temperature in hundredths of a
// degree, the humidity in hundredths of a percent and, in out_tuser, the CRC flag; when any
// word CRC failed the flag and all values are zero. Scaling runs in a three-stage pipeline
// with both multiplies in the first stage and a reciprocal division by 65535, which takes
// one frame per cycle while the output is not stalled.
module sensor_word_crc_frame_decoder
  import swcfd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] co2_ppm, [30:16] temperature_centi_c,
                                  // [44:31] humidity_centi_pct, [47:45] zero
  output logic        out_tuser   // [0] crc_ok
);

  logic         q_push, q_pop, q_full, q_valid;
  swcfd_frame_t q_in, q_head;

  swcfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (q_push),
    .frame     (q_in)
  );

  swcfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head),
    .full       (q_full)
  );

  swcfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("Frame pushed into a full queue.");

  a_bad_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("Result with failed CRC carries nonzero values.");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[44:31] <= HUM_MAX))
    else $error("Humidity out of range.");

  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("Pop from an empty queue.");

endmodule
